>>> design/pcts_pkg.sv
// Shared definitions for the priority/counter task scheduler.
// Holds table sizes, the sequencer state type, the task entry layout and the
// counter arithmetic helpers. Depends on nothing.
package pcts_pkg;

  localparam int TASK_COUNT = 16;
  localparam int PRIO_BITS  = 8;
  localparam int IDX_W      = $clog2(TASK_COUNT);
  localparam int SLICE_W    = 9;
  localparam int CMP_W      = ((IDX_W > 4) ? IDX_W : 4) + 1;
  localparam int SUM_W      = ((SLICE_W > PRIO_BITS) ? SLICE_W : PRIO_BITS) + 1;

  localparam logic [SLICE_W-1:0] SLICE_MAX = {SLICE_W{1'b1}};

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC_RD,
    S_DEC,
    S_SCAN,
    S_SCAN_END,
    S_CUR_RD,
    S_CUR
  } state_t;

  typedef struct packed {
    logic                 ready;
    logic [PRIO_BITS-1:0] prio;
    logic [SLICE_W-1:0]   slice;
  } entry_t;

  // Charge one unit of time slice, holding at zero.
  function automatic logic [SLICE_W-1:0] slice_dec(input logic [SLICE_W-1:0] s);
    return (s == '0) ? '0 : s - SLICE_W'(1);
  endfunction

  // Recompute a counter as half the old value plus the priority, saturated.
  function automatic logic [SLICE_W-1:0] slice_refill(input logic [SLICE_W-1:0]   s,
                                                      input logic [PRIO_BITS-1:0] p);
    logic [SUM_W-1:0] v;
    v = SUM_W'(s >> 1) + SUM_W'(p);
    return (v > SUM_W'(SLICE_MAX)) ? SLICE_MAX : SLICE_W'(v);
  endfunction

endpackage

>>> design/priority_counter_task_scheduler.sv
// Priority/counter task scheduler: task table memory, scan sequencer and
// result register. Depends on pcts_pkg.
//
// Usage:
//   Request channel (req_valid/req_stall) carries one item: action selects
//   a timer tick or a load of one task slot (task_index, priority_req,
//   runnable). Response channel (rsp_valid/rsp_stall) returns one result per
//   request: the running task, its counter and priority, switched and
//   no_task.
//   The task table sits in a single-port-read memory that the sequencer
//   walks one entry per cycle. A load writes its slot (if in range) and then
//   reads the current task back for the result. A tick charges the running
//   task's counter; when the idle task is current or that counter reaches
//   zero it searches slots N-1 down to 1 (N = TASK_COUNT, 16 here), and if
//   none is found while a ready task has a nonzero priority, it searches
//   once more with counter recompute.
//   The recompute pass is fused with the second search pass.
//   One request is worked on at a time; req_stall is high while it runs.
//   A new request is taken while an earlier result still waits in the
//   output register; a finishing request holds until that slot frees.
//   Reset (rst, synchronous) clears the per-entry valid bits, so every slot
//   reads as zero, makes the idle task current and empties the output.
//   While rsp_stall is high the result and rsp_valid hold.
module priority_counter_task_scheduler
  import pcts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       action,
  input  logic [3:0] task_index,
  input  logic [7:0] priority_req,
  input  logic       runnable,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [3:0] running_task,
  output logic       switched,
  output logic [8:0] task_counter,
  output logic [7:0] task_priority,
  output logic       no_task
);

  state_t state, state_next;

  // Task table and its per-entry valid bits
  entry_t                mem [TASK_COUNT];
  entry_t                rd_data;
  logic                  rd_ok;
  logic [TASK_COUNT-1:0] valid;
  entry_t                rd_word;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             wr_en;

  // Sequencer registers
  logic [IDX_W-1:0]     cur;
  logic [IDX_W-1:0]     scan_idx;
  logic [IDX_W-1:0]     chk_idx;
  logic [IDX_W-1:0]     best;
  logic [PRIO_BITS-1:0] top;
  logic                 chk_on;
  logic                 pass2;
  logic                 any_elig;
  logic                 sw;
  logic                 none;

  // Shared compare unit results
  logic [SLICE_W-1:0]   cand_slice;
  logic [SLICE_W-1:0]   dec_slice;
  logic                 hit;
  logic [IDX_W-1:0]     best_next;
  logic [PRIO_BITS-1:0] top_next;
  logic                 any_next;
  logic                 in_range;
  logic                 out_free;
  logic                 retry;

  assign req_stall = (state != S_IDLE);
  assign rd_word   = rd_ok ? rd_data : '0;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign in_range  = (CMP_W'(task_index) < CMP_W'(TASK_COUNT));

  // Evaluate the entry read last cycle against the best so far
  assign cand_slice = pass2 ? slice_refill(rd_word.slice, rd_word.prio) : rd_word.slice;
  assign dec_slice  = slice_dec(rd_word.slice);
  assign hit        = chk_on && rd_word.ready && (cand_slice != '0) && (rd_word.prio > top);
  assign best_next  = hit ? chk_idx : best;
  assign top_next   = hit ? rd_word.prio : top;
  assign any_next   = any_elig | (chk_on && rd_word.ready && (rd_word.prio != '0));
  assign retry      = !pass2 && any_next && (best_next == '0);

  // Next state and memory port control
  always_comb begin
    state_next = state;
    rd_addr    = cur;
    wr_en      = 1'b0;
    wr_addr    = chk_idx;
    wr_data    = '{ready: rd_word.ready, prio: rd_word.prio, slice: cand_slice};
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (action == ACT_LOAD) begin
            wr_en      = in_range;
            wr_addr    = IDX_W'(task_index);
            wr_data    = '{ready: runnable, prio: PRIO_BITS'(priority_req), slice: '0};
            state_next = S_CUR_RD;
          end else if (cur == '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DEC_RD;
          end
        end
      end
      S_DEC_RD: state_next = S_DEC;
      S_DEC: begin
        wr_en      = 1'b1;
        wr_addr    = cur;
        wr_data    = '{ready: rd_word.ready, prio: rd_word.prio, slice: dec_slice};
        state_next = (dec_slice == '0) ? S_SCAN : S_CUR_RD;
      end
      S_SCAN: begin
        rd_addr = scan_idx;
        wr_en   = pass2 && chk_on;
        if (scan_idx == IDX_W'(1)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        wr_en      = pass2 && chk_on;
        state_next = retry ? S_SCAN : S_CUR_RD;
      end
      S_CUR_RD: state_next = S_CUR;
      S_CUR: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Table storage, read data registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits and state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_ok <= valid[rd_addr];
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      chk_on    <= 1'b0;
      pass2     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // raise the result when it is loaded, drop it once taken
      if ((state == S_CUR) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            sw       <= 1'b0;
            none     <= 1'b0;
            pass2    <= 1'b0;
            chk_on   <= 1'b0;
            scan_idx <= IDX_W'(TASK_COUNT - 1);
            best     <= '0;
            top      <= '0;
            any_elig <= 1'b0;
          end
        end
        S_SCAN: begin
          chk_idx  <= scan_idx;
          chk_on   <= 1'b1;
          scan_idx <= scan_idx - IDX_W'(1);
          best     <= best_next;
          top      <= top_next;
          any_elig <= any_next;
        end
        S_SCAN_END: begin
          chk_on <= 1'b0;
          if (retry) begin
            // nothing found: recompute counters while searching again
            pass2    <= 1'b1;
            scan_idx <= IDX_W'(TASK_COUNT - 1);
            best     <= '0;
            top      <= '0;
          end else if (!pass2 && !any_next) begin
            none <= 1'b1;
          end else if ((best_next != '0) && (best_next != cur)) begin
            cur <= best_next;
            sw  <= 1'b1;
          end
        end
        S_CUR: begin
          if (out_free) begin
            running_task  <= 4'(cur);
            switched      <= sw;
            task_counter  <= 9'(rd_word.slice);
            task_priority <= 8'(rd_word.prio);
            no_task       <= none;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/pcts_checker.sv
// Port-level checks for the priority/counter task scheduler.
// Watches the top level's ports only; bound to the top level below.
module pcts_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic [3:0] running_task,
  input logic       switched,
  input logic       no_task
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // Never switch and report no task at once
  a_sw_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(switched && no_task))
    else $error("switched together with no_task");

  // A switch never lands on the idle task
  a_sw_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && switched |-> running_task != 4'd0)
    else $error("switched to the idle task");

  // Come out of reset ready for a request
  a_rst_ready: assert property (@(posedge clk)
    rst |=> !req_stall)
    else $error("request port stalled after reset");

  // Stall the next request while one is at work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request port open while busy");

endmodule

bind priority_counter_task_scheduler pcts_checker u_pcts_checker (.*);

>>> dv/priority_counter_task_scheduler_checker.sv
// Checker for the priority/counter task scheduler: watches both channels,
// predicts each result from its own task table and compares field by field.
// Depends on pcts_pkg for table sizes and action codes.
module priority_counter_task_scheduler_checker
  import pcts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_stall,
  input  logic       action,
  input  logic [3:0] task_index,
  input  logic [7:0] priority_req,
  input  logic       runnable,
  input  logic       rsp_valid,
  input  logic       rsp_stall,
  input  logic [3:0] running_task,
  input  logic       switched,
  input  logic [8:0] task_counter,
  input  logic [7:0] task_priority,
  input  logic       no_task,
  output int         fail_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]           running_task;
    logic                 switched;
    logic [SLICE_W-1:0]   task_counter;
    logic [PRIO_BITS-1:0] task_prio;
    logic                 no_task;
  } sched_result_t;

  // Shadow task table and running task.
  logic [PRIO_BITS-1:0] prio_tbl  [TASK_COUNT];
  logic [SLICE_W-1:0]   slice_tbl [TASK_COUNT];
  logic                 ready_tbl [TASK_COUNT];
  logic [IDX_W-1:0]     cur_task;

  sched_result_t expected_results[$];

  // Pick the runnable slot with a nonzero counter and the top priority;
  // scanning downward with a strict compare gives ties to the higher index.
  function automatic logic [IDX_W-1:0] pick_best_task();
    logic [IDX_W-1:0]     best;
    logic [PRIO_BITS-1:0] top;
    best = '0;
    top  = '0;
    for (int i = TASK_COUNT - 1; i >= 1; i--) begin
      if (ready_tbl[i] && slice_tbl[i] != '0 && prio_tbl[i] > top) begin
        top  = prio_tbl[i];
        best = IDX_W'(i);
      end
    end
    return best;
  endfunction

  // Advance the shadow scheduler by one request and return its result.
  task automatic schedule_request(input logic act, input logic [3:0] idx,
                                  input logic [7:0] prio, input logic run,
                                  output sched_result_t res);
    logic             need_search;
    logic             any_ready;
    logic [IDX_W-1:0] next_task;
    logic [SLICE_W:0] sum;
    res = '0;
    if (act == ACT_LOAD) begin
      prio_tbl[idx]  = PRIO_BITS'(prio);
      ready_tbl[idx] = run;
      slice_tbl[idx] = '0;
    end else begin
      need_search = 1'b0;
      if (cur_task == '0) begin
        need_search = 1'b1;
      end else begin
        if (slice_tbl[cur_task] != '0) slice_tbl[cur_task] = slice_tbl[cur_task] - SLICE_W'(1);
        if (slice_tbl[cur_task] == '0) need_search = 1'b1;
      end
      if (need_search) begin
        any_ready = 1'b0;
        for (int i = 1; i < TASK_COUNT; i++) begin
          if (ready_tbl[i] && prio_tbl[i] != '0) any_ready = 1'b1;
        end
        if (!any_ready) begin
          res.no_task = 1'b1;
        end else begin
          next_task = pick_best_task();
          // Recompute every non-idle counter and search once more.
          if (next_task == '0) begin
            for (int i = 1; i < TASK_COUNT; i++) begin
              sum = (SLICE_W + 1)'(slice_tbl[i] >> 1) + (SLICE_W + 1)'(prio_tbl[i]);
              slice_tbl[i] = (sum > (SLICE_W + 1)'(SLICE_MAX)) ? SLICE_MAX : SLICE_W'(sum);
            end
            next_task = pick_best_task();
          end
          if (next_task != '0 && next_task != cur_task) begin
            cur_task     = next_task;
            res.switched = 1'b1;
          end
        end
      end
    end
    res.running_task = 4'(cur_task);
    res.task_counter = slice_tbl[cur_task];
    res.task_prio    = prio_tbl[cur_task];
  endtask

  // Check results first, then log new requests, so an empty store is judged right.
  always @(posedge clk) begin
    sched_result_t exp_res;
    sched_result_t new_res;
    if (rst) begin
      for (int i = 0; i < TASK_COUNT; i++) begin
        prio_tbl[i]  = '0;
        slice_tbl[i] = '0;
        ready_tbl[i] = 1'b0;
      end
      cur_task = '0;
      expected_results.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: task %0d", running_task);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (running_task !== exp_res.running_task) begin
            $error("running_task: expected %0d, got %0d", exp_res.running_task, running_task);
            fail_count++;
          end
          if (switched !== exp_res.switched) begin
            $error("switched: expected %0d, got %0d", exp_res.switched, switched);
            fail_count++;
          end
          if (task_counter !== exp_res.task_counter) begin
            $error("task_counter: expected %0d, got %0d", exp_res.task_counter, task_counter);
            fail_count++;
          end
          if (task_priority !== exp_res.task_prio) begin
            $error("task_priority: expected %0d, got %0d", exp_res.task_prio, task_priority);
            fail_count++;
          end
          if (no_task !== exp_res.no_task) begin
            $error("no_task: expected %0d, got %0d", exp_res.no_task, no_task);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        schedule_request(action, task_index, priority_req, runnable, new_res);
        expected_results.push_back(new_res);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

>>> dv/priority_counter_task_scheduler_tb.sv
// Top of the task scheduler bench: clock, reset, request and response
// drivers, watchdog and verdict. Depends on pcts_pkg, the scheduler RTL and
// priority_counter_task_scheduler_checker.
module priority_counter_task_scheduler_tb;
  import pcts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1800;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AT         = 600;
  localparam int DRAIN_CYCLES    = 60;

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic       action;
  logic [3:0] task_index;
  logic [7:0] priority_req;
  logic       runnable;
  logic       rsp_valid;
  logic       rsp_stall;
  logic [3:0] running_task;
  logic       switched;
  logic [8:0] task_counter;
  logic [7:0] task_priority;
  logic       no_task;

  int fail_count;
  int pending_count;
  int sent_count;
  int taken_count;

  always #5 clk = ~clk;

  priority_counter_task_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .task_index   (task_index),
    .priority_req (priority_req),
    .runnable     (runnable),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .running_task (running_task),
    .switched     (switched),
    .task_counter (task_counter),
    .task_priority(task_priority),
    .no_task      (no_task)
  );

  priority_counter_task_scheduler_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .action       (action),
    .task_index   (task_index),
    .priority_req (priority_req),
    .runnable     (runnable),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .running_task (running_task),
    .switched     (switched),
    .task_counter (task_counter),
    .task_priority(task_priority),
    .no_task      (no_task),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_request(input logic act, input logic [3:0] idx,
                              input logic [7:0] prio, input logic run);
    int gap;
    gap = (((sent_count / 150) % 4) == 2) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    action       <= act;
    task_index   <= idx;
    priority_req <= prio;
    runnable     <= run;
    req_valid    <= 1'b1;
    do @(posedge clk); while (!(req_valid && !req_stall));
    sent_count++;
  endtask

  // Mostly small priorities so time slices run out and searches happen often.
  function automatic logic [7:0] draw_priority();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 8'($urandom_range(0, 7));
    if (pick < 90) return 8'($urandom_range(8, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  // Response side: random stalls, quiet stretches and one long hold-off.
  initial begin
    int gap;
    bit held;
    rsp_stall   = 1'b0;
    taken_count = 0;
    held        = 1'b0;
    @(negedge rst);
    forever begin
      gap = (((taken_count / 130) % 4) == 1) ? 0 : $urandom_range(0, 19);
      if (!held && taken_count == HOLD_AT) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid && !rsp_stall));
      taken_count++;
    end
  end

  // Watchdog: end the run when nothing is accepted for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int pick;
    logic [3:0] idx;
    req_valid    = 1'b0;
    action       = ACT_TICK;
    task_index   = '0;
    priority_req = '0;
    runnable     = 1'b0;
    sent_count   = 0;
    rst          = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, idle slot, zero priority, not runnable.
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_LOAD, 4'd0,  8'd255, 1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_LOAD, 4'd5,  8'd0,   1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_LOAD, 4'd9,  8'd3,   1'b0);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    // First real task: recompute from idle, then run the slice down.
    send_request(ACT_LOAD, 4'd7,  8'd2,   1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    // Equal priorities, and a reload of the running slot clearing its counter.
    send_request(ACT_LOAD, 4'd12, 8'd2,   1'b1);
    send_request(ACT_LOAD, 4'd7,  8'd2,   1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    // Large priorities; deschedule the running task.
    send_request(ACT_LOAD, 4'd15, 8'd255, 1'b1);
    send_request(ACT_LOAD, 4'd14, 8'd170, 1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_LOAD, 4'd15, 8'd255, 1'b0);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);
    send_request(ACT_LOAD, 4'd3,  8'd85,  1'b1);
    send_request(ACT_TICK, 4'd0,  8'd0,   1'b0);

    // Random: mostly ticks, loads spread over all slots.
    repeat (RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        idx = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, TASK_COUNT - 1));
        send_request(ACT_LOAD, idx, draw_priority(), ($urandom_range(0, 4) != 0));
      end else begin
        send_request(ACT_TICK, 4'($urandom), 8'($urandom), 1'($urandom));
      end
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then allow for stray late results.
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
